// File: hw/rtl/twf_pkg.sv
package twf_pkg;

  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_WIND_DIR_X    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIND_DIR_Y    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIND_DIR_Z    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WIND_STRENGTH = 2'd3;

endpackage

// File: hw/rtl/triangle_wind_force_top.sv
// Throughput: one triangle per cycle while the output is not stalled; the square root and the divider
// are bit-per-stage pipelines of VALUE_WIDTH stages each, and set the depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset (rst, synchronous, active high) clears all valid bits and the four wind registers.
module triangle_wind_force_top #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [twf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [VALUE_WIDTH-1:0]                 cfg_data,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  logic [((9*VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // force_x, force_y, force_z
  output logic [((3*VALUE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // clipped
  output logic                                   m_axis_tuser
);
  import twf_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int PW  = 2*W + 4;
  localparam int RW  = W + 3;
  localparam int DWO = ((3*W+7)/8)*8;

  localparam logic signed [PW-1:0] SMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = ~SMAX;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                vld;
    logic                deg;
    logic                clip;
    logic signed [W-1:0] nx;
    logic signed [W-1:0] ny;
    logic signed [W-1:0] nz;
  } ctl_t;

  function automatic logic [W:0] sat_shift(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    logic [W:0] r;
    t = p >>> F;
    priority if (t > SMAX) r = {1'b1, VMAX};
    else if (t < SMIN)     r = {1'b1, VMIN};
    else                   r = {1'b0, t[W-1:0]};
    return r;
  endfunction

  logic signed [W-1:0] wind_dir_x, wind_dir_y, wind_dir_z, wind_strength;
  logic en;

  assign cfg_ready     = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      wind_dir_x    <= '0;
      wind_dir_y    <= '0;
      wind_dir_z    <= '0;
      wind_strength <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIND_DIR_X:    wind_dir_x    <= cfg_data;
        REG_WIND_DIR_Y:    wind_dir_y    <= cfg_data;
        REG_WIND_DIR_Z:    wind_dir_z    <= cfg_data;
        REG_WIND_STRENGTH: wind_strength <= cfg_data;
      endcase
    end
  end

  // stage 1: edges
  logic signed [W-1:0] first_x, first_y, first_z, second_x, second_y, second_z;
  logic signed [W-1:0] third_x, third_y, third_z;
  assign first_x  = s_axis_tdata[0*W +: W];
  assign first_y  = s_axis_tdata[1*W +: W];
  assign first_z  = s_axis_tdata[2*W +: W];
  assign second_x = s_axis_tdata[3*W +: W];
  assign second_y = s_axis_tdata[4*W +: W];
  assign second_z = s_axis_tdata[5*W +: W];
  assign third_x  = s_axis_tdata[6*W +: W];
  assign third_y  = s_axis_tdata[7*W +: W];
  assign third_z  = s_axis_tdata[8*W +: W];

  logic v1;
  logic signed [W:0] e1x, e1y, e1z, e2x, e2y, e2z;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_axis_tvalid;
    if (en) begin
      e1x <= (W+1)'(second_x) - (W+1)'(first_x);
      e1y <= (W+1)'(second_y) - (W+1)'(first_y);
      e1z <= (W+1)'(second_z) - (W+1)'(first_z);
      e2x <= (W+1)'(third_x) - (W+1)'(first_x);
      e2y <= (W+1)'(third_y) - (W+1)'(first_y);
      e2z <= (W+1)'(third_z) - (W+1)'(first_z);
    end
  end

  // stage 2: cross-product partial products
  logic v2;
  logic signed [2*W+1:0] cp0, cp1, cp2, cp3, cp4, cp5;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      cp0 <= e1y * e2z;
      cp1 <= e1z * e2y;
      cp2 <= e1z * e2x;
      cp3 <= e1x * e2z;
      cp4 <= e1x * e2y;
      cp5 <= e1y * e2x;
    end
  end

  // stage 3: normal, quantized and saturated
  logic [W:0] snx, sny, snz;
  assign snx = sat_shift(PW'(cp0) - PW'(cp1));
  assign sny = sat_shift(PW'(cp2) - PW'(cp3));
  assign snz = sat_shift(PW'(cp4) - PW'(cp5));

  ctl_t c3;
  always_ff @(posedge clk) begin
    if (rst) c3.vld <= 1'b0;
    else if (en) c3.vld <= v2;
    if (en) begin
      c3.nx   <= snx[W-1:0];
      c3.ny   <= sny[W-1:0];
      c3.nz   <= snz[W-1:0];
      c3.clip <= snx[W] | sny[W] | snz[W];
      c3.deg  <= (snx[W-1:0] == '0) && (sny[W-1:0] == '0) && (snz[W-1:0] == '0);
    end
  end

  // stage 4: squares and wind products
  ctl_t c4;
  logic signed [2*W-1:0] q0, q1, q2, d0, d1, d2;
  always_ff @(posedge clk) begin
    if (rst) c4.vld <= 1'b0;
    else if (en) c4.vld <= c3.vld;
    if (en) begin
      c4.deg  <= c3.deg;
      c4.clip <= c3.clip;
      c4.nx   <= c3.nx;
      c4.ny   <= c3.ny;
      c4.nz   <= c3.nz;
      q0 <= c3.nx * c3.nx;
      q1 <= c3.ny * c3.ny;
      q2 <= c3.nz * c3.nz;
      d0 <= c3.nx * wind_dir_x;
      d1 <= c3.ny * wind_dir_y;
      d2 <= c3.nz * wind_dir_z;
    end
  end

  // stage 5: sums
  ctl_t c5;
  logic signed [2*W+1:0] sq_sum, dot_sum;
  always_ff @(posedge clk) begin
    if (rst) c5.vld <= 1'b0;
    else if (en) c5.vld <= c4.vld;
    if (en) begin
      c5.deg  <= c4.deg;
      c5.clip <= c4.clip;
      c5.nx   <= c4.nx;
      c5.ny   <= c4.ny;
      c5.nz   <= c4.nz;
      sq_sum  <= (2*W+2)'(q0) + (2*W+2)'(q1) + (2*W+2)'(q2);
      dot_sum <= (2*W+2)'(d0) + (2*W+2)'(d1) + (2*W+2)'(d2);
    end
  end

  // square root, one root bit per stage
  ctl_t                  rt_c    [W+1];
  logic [RW-1:0]         rt_rem  [W+1];
  logic [W-1:0]          rt_root [W+1];
  logic [2*W-1:0]        rt_x    [W+1];
  logic signed [2*W+1:0] rt_dot  [W+1];

  assign rt_c[0]    = c5;
  assign rt_rem[0]  = '0;
  assign rt_root[0] = '0;
  assign rt_x[0]    = sq_sum[2*W-1:0];
  assign rt_dot[0]  = dot_sum;

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    logic [RW-1:0] cand, trial;
    logic          ge;
    assign cand  = {rt_rem[i][RW-3:0], rt_x[i][2*W-1:2*W-2]};
    assign trial = RW'({rt_root[i], 2'b01});
    assign ge    = cand >= trial;
    always_ff @(posedge clk) begin
      if (rst) rt_c[i+1].vld <= 1'b0;
      else if (en) rt_c[i+1] <= rt_c[i];
      if (en) begin
        rt_rem[i+1]  <= ge ? cand - trial : cand;
        rt_root[i+1] <= {rt_root[i][W-2:0], ge};
        rt_x[i+1]    <= rt_x[i] << 2;
        rt_dot[i+1]  <= rt_dot[i];
      end
    end
  end

  // divider setup
  logic [2*W+1:0] dot_mag;
  assign dot_mag = rt_dot[W][2*W+1] ? -rt_dot[W] : rt_dot[W];

  ctl_t           dv_c   [W+1];
  logic [W-1:0]   dv_rem [W+1];
  logic [W-1:0]   dv_q   [W+1];
  logic [W-1:0]   dv_low [W+1];
  logic [W-1:0]   dv_len [W+1];
  logic           dv_neg [W+1];
  logic           dv_big [W+1];

  always_ff @(posedge clk) begin
    if (rst) dv_c[0].vld <= 1'b0;
    else if (en) dv_c[0] <= rt_c[W];
    if (en) begin
      dv_neg[0] <= rt_dot[W][2*W+1];
      dv_big[0] <= dot_mag[2*W:0] >= (2*W+1)'({rt_root[W], {W{1'b0}}});
      dv_rem[0] <= dot_mag[2*W-1:W];
      dv_low[0] <= dot_mag[W-1:0];
      dv_q[0]   <= '0;
      dv_len[0] <= rt_root[W];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < W; i++) begin : g_div
    logic [W:0] cand;
    logic       ge;
    logic [W:0] diff;
    assign cand = {dv_rem[i], dv_low[i][W-1]};
    assign ge   = cand >= {1'b0, dv_len[i]};
    assign diff = cand - {1'b0, dv_len[i]};
    always_ff @(posedge clk) begin
      if (rst) dv_c[i+1].vld <= 1'b0;
      else if (en) dv_c[i+1] <= dv_c[i];
      if (en) begin
        dv_rem[i+1] <= ge ? diff[W-1:0] : cand[W-1:0];
        dv_q[i+1]   <= {dv_q[i][W-2:0], ge};
        dv_low[i+1] <= dv_low[i] << 1;
        dv_len[i+1] <= dv_len[i];
        dv_neg[i+1] <= dv_neg[i];
        dv_big[i+1] <= dv_big[i];
      end
    end
  end

  // alignment: sign and saturation of the quotient
  logic [W-1:0] s_val;
  logic         s_clip;
  always_comb begin
    priority if (dv_big[W]) begin
      s_clip = 1'b1;
      s_val  = dv_neg[W] ? VMIN : VMAX;
    end else if (!dv_neg[W]) begin
      s_clip = dv_q[W] >= VMIN;
      s_val  = s_clip ? VMAX : dv_q[W];
    end else begin
      s_clip = dv_q[W] > VMIN;
      s_val  = s_clip ? VMIN : -dv_q[W];
    end
  end

  ctl_t ca;
  logic signed [W-1:0] s_reg;
  always_ff @(posedge clk) begin
    if (rst) ca.vld <= 1'b0;
    else if (en) ca.vld <= dv_c[W].vld;
    if (en) begin
      ca.deg  <= dv_c[W].deg;
      ca.clip <= dv_c[W].clip | (s_clip & !dv_c[W].deg);
      ca.nx   <= dv_c[W].nx;
      ca.ny   <= dv_c[W].ny;
      ca.nz   <= dv_c[W].nz;
      s_reg   <= s_val;
    end
  end

  // scale
  ctl_t cb;
  logic signed [2*W-1:0] sk;
  always_ff @(posedge clk) begin
    if (rst) cb.vld <= 1'b0;
    else if (en) cb <= ca;
    if (en) sk <= s_reg * wind_strength;
  end

  logic [W:0] m_sat;
  assign m_sat = sat_shift(PW'(sk));

  ctl_t cm;
  logic signed [W-1:0] m_reg;
  always_ff @(posedge clk) begin
    if (rst) cm.vld <= 1'b0;
    else if (en) cm.vld <= cb.vld;
    if (en) begin
      cm.deg  <= cb.deg;
      cm.clip <= cb.clip | (m_sat[W] & !cb.deg);
      cm.nx   <= cb.nx;
      cm.ny   <= cb.ny;
      cm.nz   <= cb.nz;
      m_reg   <= m_sat[W-1:0];
    end
  end

  // force products
  ctl_t cf;
  logic signed [2*W-1:0] fpx, fpy, fpz;
  always_ff @(posedge clk) begin
    if (rst) cf.vld <= 1'b0;
    else if (en) cf <= cm;
    if (en) begin
      fpx <= cm.nx * m_reg;
      fpy <= cm.ny * m_reg;
      fpz <= cm.nz * m_reg;
    end
  end

  logic [W:0] fx_sat, fy_sat, fz_sat;
  assign fx_sat = sat_shift(PW'(fpx));
  assign fy_sat = sat_shift(PW'(fpy));
  assign fz_sat = sat_shift(PW'(fpz));

  // output register
  logic [W-1:0] force_x, force_y, force_z;
  logic         clipped;
  logic         out_deg;
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= cf.vld;
    if (en) begin
      out_deg <= cf.deg;
      if (cf.deg) begin
        force_x <= '0;
        force_y <= '0;
        force_z <= '0;
        clipped <= cf.clip;
      end else begin
        force_x <= fx_sat[W-1:0];
        force_y <= fy_sat[W-1:0];
        force_z <= fz_sat[W-1:0];
        clipped <= cf.clip | fx_sat[W] | fy_sat[W] | fz_sat[W];
      end
    end
  end

  assign m_axis_tdata = DWO'({force_z, force_y, force_x});
  assign m_axis_tuser = clipped;

  a_deg_no_clip: assert property (@(posedge clk) disable iff (rst)
    c3.vld && c3.deg |-> !c3.clip)
    else $error("degenerate normal flagged as clipped");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    dv_c[0].vld && !dv_c[0].deg |-> dv_len[0] != '0)
    else $error("zero length for a non-degenerate normal");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_c[W].vld && !dv_c[W].deg && !dv_big[W] |-> dv_rem[W] < dv_len[W])
    else $error("divider remainder out of range");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_deg |-> force_x == '0 && force_y == '0 && force_z == '0 && !clipped)
    else $error("degenerate triangle with nonzero force");

endmodule
